/* hdl/rgbcsp_pkg.sv */
`timescale 1ns / 1ps

package rgbcsp_pkg;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;

    localparam logic [4:0] HEX_NONE = 5'd16;

    localparam logic [2:0] FULL_DIGITS = 3'd6;
    localparam logic [8:0] DEC_SAT    = 9'd256;
    localparam logic [7:0] COMP_MAX   = 8'd255;
    localparam logic [11:0] DEC_RADIX = 12'd10;

    localparam logic [1:0] MODE_LEAD     = 2'd0;
    localparam logic [1:0] MODE_HEX      = 2'd1;
    localparam logic [1:0] MODE_DEC_WAIT = 2'd2;
    localparam logic [1:0] MODE_DEC_NUM  = 2'd3;

    localparam logic [2:0] TRI_HASH   = 3'd0;
    localparam logic [2:0] TRI_D1     = 3'd1;
    localparam logic [2:0] TRI_D2     = 3'd2;
    localparam logic [2:0] TRI_AFTER2 = 3'd3;
    localparam logic [2:0] TRI_FAILED = 3'd4;

    localparam logic [1:0] COMP_RED   = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;

    typedef struct packed {
        logic [1:0]  parse_mode;
        logic [2:0]  full_digit_count;
        logic [23:0] full_hex_value;
        logic        full_attempt_failed;
        logic [2:0]  triplet_phase;
        logic [7:0]  triplet_value;
        logic [8:0]  decimal_accumulator;
        logic [1:0]  component_index;
        logic [7:0]  red_part;
        logic [7:0]  green_part;
        logic        settled_flag;
        logic [23:0] settled_color;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        parse_mode:          MODE_LEAD,
        full_digit_count:    3'd0,
        full_hex_value:      24'd0,
        full_attempt_failed: 1'b0,
        triplet_phase:       TRI_HASH,
        triplet_value:       8'd0,
        decimal_accumulator: 9'd0,
        component_index:     2'd0,
        red_part:            8'd0,
        green_part:          8'd0,
        settled_flag:        1'b0,
        settled_color:       24'd0
    };

    typedef struct packed {
        logic        emit;
        logic [23:0] color;
    } parse_result_t;

    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] h;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            h = {1'b0, c[3:0]};
        end else if ((c >= CHAR_UP_A && c <= CHAR_UP_F) ||
                     (c >= CHAR_LO_A && c <= CHAR_LO_F)) begin
            h = {1'b0, c[3:0]} + 5'd9;
        end else begin
            h = HEX_NONE;
        end
        return h;
    endfunction

endpackage

/* hdl/rgbcsp_in_stage.sv */
`timescale 1ns / 1ps

module rgbcsp_in_stage
    import rgbcsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       take,
    output logic       char_valid,
    output logic [7:0] char_code
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] char_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            char_reg <= s_tdata;
        end
    end

    assign char_valid = valid_reg;
    assign char_code  = char_reg;

endmodule

/* hdl/rgbcsp_parser.sv */
`timescale 1ns / 1ps

module rgbcsp_parser
    import rgbcsp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          advance,
    input  logic [7:0]    char_code,
    output parse_result_t result
);

    parse_state_t state_reg;
    parse_state_t state_next;

    always_comb begin
        parse_state_t s;
        logic [4:0]   hx;
        logic         is_dig;
        logic [3:0]   dig;
        logic         part_done;
        logic [11:0]  dec_sum;
        logic [7:0]   comp;

        s         = state_reg;
        hx        = hex_of(char_code);
        is_dig    = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
        dig       = char_code[3:0];
        part_done = 1'b0;
        dec_sum   = {3'd0, s.decimal_accumulator} * DEC_RADIX + {8'd0, dig};
        comp      = (s.decimal_accumulator > {1'b0, COMP_MAX}) ? COMP_MAX
                                                              : s.decimal_accumulator[7:0];

        if (!s.settled_flag) begin
            unique case (s.parse_mode)
                MODE_LEAD, MODE_DEC_WAIT: begin
                    if (char_code == CHAR_SPACE) begin
                        s.parse_mode = s.parse_mode;
                    end else if (s.parse_mode == MODE_LEAD && char_code == CHAR_HASH) begin
                        s.parse_mode    = MODE_HEX;
                        s.triplet_phase = TRI_D1;
                    end else if (is_dig) begin
                        s.decimal_accumulator = {5'd0, dig};
                        s.parse_mode          = MODE_DEC_NUM;
                    end else begin
                        s.settled_flag  = 1'b1;
                        s.settled_color = 24'd0;
                    end
                end
                MODE_HEX: begin
                    if (!s.full_attempt_failed) begin
                        if (s.full_digit_count < FULL_DIGITS) begin
                            if (hx[4]) begin
                                s.full_attempt_failed = 1'b1;
                            end else begin
                                s.full_hex_value   = {s.full_hex_value[19:0], hx[3:0]};
                                s.full_digit_count = s.full_digit_count + 3'd1;
                            end
                        end else if (hx[4] && char_code != CHAR_HASH) begin
                            s.settled_flag  = 1'b1;
                            s.settled_color = {s.full_hex_value[7:0],
                                               s.full_hex_value[15:8],
                                               s.full_hex_value[23:16]};
                        end else begin
                            s.full_attempt_failed = 1'b1;
                        end
                    end
                    if (!s.settled_flag && s.triplet_phase != TRI_FAILED) begin
                        unique case (s.triplet_phase)
                            TRI_HASH: begin
                                if (char_code == CHAR_HASH) begin
                                    s.triplet_phase = TRI_D1;
                                end else if (char_code != CHAR_SPACE) begin
                                    s.triplet_phase = TRI_FAILED;
                                end
                            end
                            TRI_D1: begin
                                if (hx[4]) begin
                                    s.triplet_phase = TRI_FAILED;
                                end else begin
                                    s.triplet_value = {4'd0, hx[3:0]};
                                    s.triplet_phase = TRI_D2;
                                end
                            end
                            TRI_D2: begin
                                if (hx[4]) begin
                                    s.triplet_value = {s.triplet_value[3:0],
                                                       s.triplet_value[3:0]};
                                    part_done = 1'b1;
                                end else begin
                                    s.triplet_value = {s.triplet_value[3:0], hx[3:0]};
                                    s.triplet_phase = TRI_AFTER2;
                                end
                            end
                            TRI_AFTER2: begin
                                if (!hx[4]) begin
                                    s.triplet_phase = TRI_FAILED;
                                end else begin
                                    part_done = 1'b1;
                                end
                            end
                            default: begin
                                s.triplet_phase = TRI_FAILED;
                            end
                        endcase
                        if (part_done) begin
                            if (s.component_index == COMP_RED ||
                                s.component_index == COMP_GREEN) begin
                                if (s.component_index == COMP_RED) begin
                                    s.red_part = s.triplet_value;
                                end else begin
                                    s.green_part = s.triplet_value;
                                end
                                s.component_index = s.component_index + 2'd1;
                                if (char_code == CHAR_HASH) begin
                                    s.triplet_phase = TRI_D1;
                                end else if (char_code == CHAR_SPACE) begin
                                    s.triplet_phase = TRI_HASH;
                                end else begin
                                    s.triplet_phase = TRI_FAILED;
                                end
                            end else begin
                                s.settled_flag  = 1'b1;
                                s.settled_color = {s.triplet_value, s.green_part,
                                                   s.red_part};
                            end
                        end
                    end
                    if (!s.settled_flag && s.full_attempt_failed &&
                        s.triplet_phase == TRI_FAILED) begin
                        s.settled_flag  = 1'b1;
                        s.settled_color = 24'd0;
                    end
                end
                MODE_DEC_NUM: begin
                    if (is_dig) begin
                        s.decimal_accumulator = (dec_sum > {3'd0, DEC_SAT}) ? DEC_SAT
                                                                            : dec_sum[8:0];
                    end else if (s.component_index == COMP_RED ||
                                 s.component_index == COMP_GREEN) begin
                        if (s.component_index == COMP_RED) begin
                            s.red_part = comp;
                        end else begin
                            s.green_part = comp;
                        end
                        s.component_index = s.component_index + 2'd1;
                        if (char_code == CHAR_SPACE) begin
                            s.parse_mode = MODE_DEC_WAIT;
                        end else begin
                            s.settled_flag  = 1'b1;
                            s.settled_color = 24'd0;
                        end
                    end else begin
                        s.settled_flag  = 1'b1;
                        s.settled_color = {comp, s.green_part, s.red_part};
                    end
                end
                default: begin
                    s.settled_flag  = 1'b1;
                    s.settled_color = 24'd0;
                end
            endcase
        end

        result.emit  = (char_code == CHAR_NUL);
        result.color = s.settled_flag ? s.settled_color : 24'd0;
        state_next   = (char_code == CHAR_NUL) ? STATE_RESET : s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    a_reset_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && char_code == CHAR_NUL |=> state_reg == STATE_RESET)
        else $error("parser state not cleared after end of string");

    a_color_needs_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.settled_color != 24'd0 |-> state_reg.settled_flag)
        else $error("settled color set without settled flag");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.triplet_phase <= TRI_FAILED)
        else $error("triplet phase out of range");

endmodule

/* hdl/rgb_color_string_parser.sv */
`timescale 1ns / 1ps
// Path: the terminating zero character is first held in the input stage register; the color
// for its string is then registered into the output register and driven on m_tdata.
// Throughput: one character per cycle; only the output register stalls intake.
// Reset: synchronous, active low; clears the input and output valid bits and all
// parser state back to the start of a string.

module rgb_color_string_parser
    import rgbcsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [23:0] color
);

    logic          char_valid;
    logic [7:0]    char_code;
    logic          advance;
    logic          out_free;
    parse_result_t result;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [23:0]   color_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = char_valid && (char_code != CHAR_NUL || out_free);

    rgbcsp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (advance),
        .char_valid (char_valid),
        .char_code  (char_code)
    );

    rgbcsp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .char_code (char_code),
        .result    (result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && result.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.emit) begin
            color_reg <= result.color;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = color_reg;

    a_nonzero_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        char_valid && char_code != CHAR_NUL |-> advance)
        else $error("ordinary character stalled");

    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && char_code == CHAR_NUL |=> m_tvalid)
        else $error("end of string gave no result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && char_valid && char_code == CHAR_NUL |-> !advance)
        else $error("pending result overwritten");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
    import rgbcsp_pkg::*;

    localparam int N_ROWS     = 9;
    localparam int PHASE_CHARS = 300;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    rgb_color_string_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    typedef struct packed {
        logic        typed;
        logic [23:0] color;
    } row_color_t;

    parse_state_t  shadow = STATE_RESET;
    logic [23:0]   colors_due [$];
    row_color_t    row_colors [$];
    logic [7:0]    text_q [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit start_hold = 1'b0;
    int fail_count = 0;
    int chars_sent = 0;
    int strings_sent = 0;
    int colors_checked = 0;

    // directed strings; a typed color is used in place of the prediction
    string       row_text  [N_ROWS] = '{"", "#A1b2C3", "#f #0 #9", "255 256 9", "#123456#",
                                        " #12345", "#1#22 #3 x", "7\3779", "9999 0 1"};
    bit          row_typed [N_ROWS] = '{1, 1, 1, 1, 1, 0, 0, 0, 0};
    logic [23:0] row_color [N_ROWS] = '{24'h000000, 24'hC3B2A1, 24'h9900FF, 24'h09FFFF,
                                        24'h000000, 24'h000000, 24'h000000, 24'h000000,
                                        24'h000000};

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return c - CHAR_ZERO;
        if (c >= CHAR_UP_A && c <= CHAR_UP_F) return c - CHAR_UP_A + 10;
        if (c >= CHAR_LO_A && c <= CHAR_LO_F) return c - CHAR_LO_A + 10;
        return -1;
    endfunction

    function automatic bit is_decimal(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic void settle(input logic [23:0] color);
        shadow.settled_flag = 1'b1;
        shadow.settled_color = color;
    endfunction

    function automatic void triplet_expect_hash(input logic [7:0] c);
        if (c == CHAR_SPACE) return;
        shadow.triplet_phase = (c == CHAR_HASH) ? TRI_D1 : TRI_FAILED;
    endfunction

    function automatic void triplet_part_done(input logic [7:0] c);
        if (shadow.component_index == COMP_RED) begin
            shadow.red_part = shadow.triplet_value;
        end else if (shadow.component_index == COMP_GREEN) begin
            shadow.green_part = shadow.triplet_value;
        end else begin
            settle({shadow.triplet_value, shadow.green_part, shadow.red_part});
            return;
        end
        shadow.component_index = shadow.component_index + 2'd1;
        shadow.triplet_phase = TRI_HASH;
        triplet_expect_hash(c);
    endfunction

    function automatic void triplet_advance(input logic [7:0] c);
        int h;
        h = hex_nibble(c);
        case (shadow.triplet_phase)
            TRI_HASH: begin
                triplet_expect_hash(c);
            end
            TRI_D1: begin
                if (h < 0) begin
                    shadow.triplet_phase = TRI_FAILED;
                end else begin
                    shadow.triplet_value = 8'(h);
                    shadow.triplet_phase = TRI_D2;
                end
            end
            TRI_D2: begin
                if (h < 0) begin
                    shadow.triplet_value = {shadow.triplet_value[3:0], shadow.triplet_value[3:0]};
                    triplet_part_done(c);
                end else begin
                    shadow.triplet_value = {shadow.triplet_value[3:0], 4'(h)};
                    shadow.triplet_phase = TRI_AFTER2;
                end
            end
            TRI_AFTER2: begin
                if (h >= 0) shadow.triplet_phase = TRI_FAILED;
                else triplet_part_done(c);
            end
            default: begin
                shadow.triplet_phase = TRI_FAILED;
            end
        endcase
    endfunction

    function automatic void six_digit_advance(input logic [7:0] c);
        int h;
        logic [23:0] v;
        h = hex_nibble(c);
        v = shadow.full_hex_value;
        if (shadow.full_digit_count < FULL_DIGITS) begin
            if (h < 0) begin
                shadow.full_attempt_failed = 1'b1;
                return;
            end
            shadow.full_hex_value = {v[19:0], 4'(h)};
            shadow.full_digit_count = shadow.full_digit_count + 3'd1;
        end else if (h < 0 && c != CHAR_HASH) begin
            settle({v[7:0], v[15:8], v[23:16]});
        end else begin
            shadow.full_attempt_failed = 1'b1;
        end
    endfunction

    function automatic void decimal_wait(input logic [7:0] c);
        if (c == CHAR_SPACE) begin
            shadow.parse_mode = MODE_DEC_WAIT;
        end else if (is_decimal(c)) begin
            shadow.decimal_accumulator = 9'(c - CHAR_ZERO);
            shadow.parse_mode = MODE_DEC_NUM;
        end else begin
            settle(24'h000000);
        end
    endfunction

    function automatic void decimal_number(input logic [7:0] c);
        int v;
        logic [7:0] comp;
        if (is_decimal(c)) begin
            v = int'(shadow.decimal_accumulator) * 10 + int'(c - CHAR_ZERO);
            shadow.decimal_accumulator = (v > 256) ? DEC_SAT : 9'(v);
            return;
        end
        comp = (shadow.decimal_accumulator > 9'd255) ? COMP_MAX : shadow.decimal_accumulator[7:0];
        if (shadow.component_index == COMP_RED) begin
            shadow.red_part = comp;
        end else if (shadow.component_index == COMP_GREEN) begin
            shadow.green_part = comp;
        end else begin
            settle({comp, shadow.green_part, shadow.red_part});
            return;
        end
        shadow.component_index = shadow.component_index + 2'd1;
        if (c == CHAR_SPACE) shadow.parse_mode = MODE_DEC_WAIT;
        else settle(24'h000000);
    endfunction

    function automatic void parse_advance(input logic [7:0] c);
        case (shadow.parse_mode)
            MODE_LEAD: begin
                if (c == CHAR_SPACE) return;
                if (c == CHAR_HASH) begin
                    shadow.parse_mode = MODE_HEX;
                    shadow.triplet_phase = TRI_D1;
                end else begin
                    decimal_wait(c);
                end
            end
            MODE_HEX: begin
                if (!shadow.full_attempt_failed) six_digit_advance(c);
                if (!shadow.settled_flag && shadow.triplet_phase != TRI_FAILED)
                    triplet_advance(c);
                if (!shadow.settled_flag && shadow.full_attempt_failed &&
                    shadow.triplet_phase == TRI_FAILED)
                    settle(24'h000000);
            end
            MODE_DEC_WAIT: begin
                decimal_wait(c);
            end
            MODE_DEC_NUM: begin
                decimal_number(c);
            end
            default: begin
                settle(24'h000000);
            end
        endcase
    endfunction

    function automatic bit predict_color(input logic [7:0] c, output logic [23:0] color);
        if (!shadow.settled_flag) parse_advance(c);
        color = 24'h000000;
        if (c != CHAR_NUL) return 1'b0;
        if (shadow.settled_flag) color = shadow.settled_color;
        shadow = STATE_RESET;
        return 1'b1;
    endfunction

    always @(posedge aclk) begin : scoreboard
        logic [23:0] want;
        logic [23:0] predicted;
        row_color_t  row;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (colors_due.size() == 0) begin
                    note_failure($sformatf("unexpected color %06h", m_tdata));
                end else begin
                    want = colors_due.pop_front();
                    colors_checked++;
                    if (m_tdata !== want)
                        note_failure($sformatf("color mismatch: expected %06h, got %06h",
                                               want, m_tdata));
                end
            end
            if (s_tvalid && s_tready) begin
                if (predict_color(s_tdata, predicted)) begin
                    row = row_colors.pop_front();
                    colors_due.push_back(row.typed ? row.color : predicted);
                end
            end
        end
    end

    always @(negedge aclk) begin : receiver
        int hold_left;
        bit hold_done;
        if (start_hold && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_char(input logic [7:0] c);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chars_sent++;
    endtask

    task automatic send_terminator(input bit typed, input logic [23:0] color);
        row_color_t row;
        row.typed = typed;
        row.color = color;
        row_colors.push_back(row);
        send_char(CHAR_NUL);
        strings_sent++;
    endtask

    function automatic logic [7:0] rand_hex_char();
        int n;
        n = $urandom_range(21);
        if (n < 10) return 8'(CHAR_ZERO + n);
        if (n < 16) return 8'(CHAR_LO_A + n - 10);
        return 8'(CHAR_UP_A + n - 16);
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(4))
            0: return CHAR_SPACE;
            1: return CHAR_HASH;
            2: return rand_hex_char();
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic build_string();
        int kind;
        int k;
        int n;
        text_q.delete();
        kind = $urandom_range(9);
        repeat ($urandom_range(2)) text_q.push_back(CHAR_SPACE);
        if (kind < 3) begin
            text_q.push_back(CHAR_HASH);
            n = ($urandom_range(4) == 0) ? $urandom_range(4, 8) : 6;
            repeat (n) text_q.push_back(rand_hex_char());
            if ($urandom_range(2) == 0) text_q.push_back(noise_char());
        end else if (kind < 6) begin
            for (k = 0; k < 3; k++) begin
                text_q.push_back(CHAR_HASH);
                n = ($urandom_range(9) == 0) ? 3 : $urandom_range(1, 2);
                repeat (n) text_q.push_back(rand_hex_char());
                repeat ($urandom_range(2)) text_q.push_back(CHAR_SPACE);
            end
        end else if (kind < 9) begin
            for (k = 0; k < 3; k++) begin
                repeat ($urandom_range(1, 4)) text_q.push_back(8'(CHAR_ZERO + $urandom_range(9)));
                if (k < 2) repeat ($urandom_range(1, 2)) text_q.push_back(CHAR_SPACE);
            end
            if ($urandom_range(3) == 0) text_q.push_back(noise_char());
        end else begin
            repeat ($urandom_range(8)) text_q.push_back(noise_char());
        end
        if (text_q.size() > 0 && $urandom_range(7) == 0)
            text_q[$urandom_range(text_q.size() - 1)] = noise_char();
    endtask

    initial begin : timeout
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int send_mix [4];
        int recv_mix [4];
        int r;
        int i;
        int ph;
        int phase_start;
        send_mix = '{0, 75, 0, 10};
        recv_mix = '{0, 0, 75, 10};
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        for (r = 0; r < N_ROWS; r++) begin
            for (i = 0; i < row_text[r].len(); i++) send_char(row_text[r][i]);
            send_terminator(row_typed[r], row_color[r]);
        end

        for (ph = 0; ph < 4; ph++) begin
            // drop valid so the last character is not offered again while draining
            @(negedge aclk);
            s_tvalid <= 1'b0;
            while (colors_due.size() != 0) @(posedge aclk);
            send_idle_pct = send_mix[ph];
            recv_stall_pct = recv_mix[ph];
            // long receiver hold-off while the sender keeps going
            if (ph == 0) start_hold = 1'b1;
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS) begin
                build_string();
                foreach (text_q[i]) send_char(text_q[i]);
                send_terminator(1'b0, 24'h000000);
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (colors_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (colors_due.size() != 0) note_failure("colors still outstanding at end of run");

        $display("covered %0d characters in %0d strings (hex, triplet, decimal, noise)",
                 chars_sent, strings_sent);
        $display("checked %0d colors over four stall mixes and one long output hold-off",
                 colors_checked);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
